[rtl/core/pid_motor_position_control_defines.svh]
// assertion macros shared by the pid motor position control rtl
// expects clk and arst_n in the scope of each use
`ifndef PID_MOTOR_POSITION_CONTROL_DEFINES_SVH
`define PID_MOTOR_POSITION_CONTROL_DEFINES_SVH

// same-cycle implication
`define PMPC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PMPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pmpc_pkg.sv]
// types, codes and constants of the pid motor position control block
// no dependencies
package pmpc_pkg;

	localparam int ANG_W      = 16;
	localparam int ERR_W      = 17;
	localparam int DT_W       = 20;
	localparam int GAIN_W     = 16;
	localparam int HB_W       = 12;
	localparam int SB_W       = 13;
	localparam int DUTY_W     = 8;
	localparam int INTEG_W    = 37;
	localparam int KIND_W     = 2;
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int DIV_N_W    = 54;
	localparam int DIV_D_W    = 20;

	localparam logic signed [ERR_W:0] HALF_TURN = 18'sd46080;
	localparam logic signed [ERR_W:0] FULL_TURN = 18'sd92160;
	localparam logic [ERR_W-1:0]      ZERO_TOL  = 17'd2560;
	localparam logic signed [INTEG_W+1:0] INTEG_LIM = 39'sd25600000000;
	localparam logic [DT_W-1:0]       US_PER_S   = 20'd1000000;
	localparam logic [DT_W-1:0]       DT_DEFAULT = 20'd1000;
	localparam logic [DUTY_W-1:0]     DUTY_LO    = 8'd125;

	localparam logic [GAIN_W-1:0] RST_PROP_GAIN  = 16'd448;
	localparam logic [GAIN_W-1:0] RST_DERIV_GAIN = 16'd0;
	localparam logic [GAIN_W-1:0] RST_INTEG_GAIN = 16'd32;
	localparam logic [HB_W-1:0]   RST_HOLD_BAND  = 12'd256;
	localparam logic [SB_W-1:0]   RST_SLOW_BAND  = 13'd1280;
	localparam logic [DUTY_W-1:0] RST_MAX_DUTY   = 8'd220;
	localparam logic [DUTY_W-1:0] RST_SLOW_DUTY  = 8'd150;
	localparam logic [DUTY_W-1:0] RST_MIN_DUTY   = 8'd150;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK = 2'd0,
		KIND_SET  = 2'd1,
		KIND_STOP = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		MODE_COAST = 2'd0,
		MODE_FWD   = 2'd1,
		MODE_REV   = 2'd2,
		MODE_BRAKE = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_DERIV_GAIN = 3'd1,
		REG_INTEG_GAIN = 3'd2,
		REG_HOLD_BAND  = 3'd3,
		REG_SLOW_BAND  = 3'd4,
		REG_MAX_DUTY   = 3'd5,
		REG_SLOW_DUTY  = 3'd6,
		REG_MIN_DUTY   = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [HB_W-1:0]   hold_band;
		logic [SB_W-1:0]   slow_band;
		logic [DUTY_W-1:0] max_duty;
		logic [DUTY_W-1:0] slow_duty;
		logic [DUTY_W-1:0] min_duty;
	} cfg_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ANG_W-1:0]  measured_angle;
		logic [ANG_W-1:0]  target_angle;
		logic [DT_W-1:0]   dt_us;
		logic              enable;
	} item_t;

	typedef struct packed {
		mode_t                    drive_mode;
		logic [DUTY_W-1:0]        duty;
		logic                     holding;
		logic                     reached;
		logic signed [ERR_W-1:0]  angle_error;
	} res_t;

	typedef struct packed {
		logic               start;
		logic [DIV_N_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [DIV_N_W-1:0] quot;
	} div_rsp_t;

endpackage

[rtl/core/pid_motor_position_control.sv]
// pid motor position control top level: config registers, input port, result register
// depends on pmpc_pkg, pmpc_seq and the assertion macro header
//
//   channel  | signals                         | direction
//   s_axis   | tvalid tready tdata tuser       | tick, set-target and stop transactions in
//   m_axis   | tvalid tready tdata             | one result transaction per control tick
//   cfg      | cfg_we cfg_index cfg_wdata      | register writes, no read-back
//
// set-target, stop and unused kinds give no result
// coast and brake ticks give their result from the error state; a pid tick runs two
// passes of the shared 2-bit-per-cycle divider, for the derivative and integral terms
// the input is not ready while a transaction is in work; arst_n clears loop state
// a finished result waits in the output register; the next transaction is
// still taken, and only its own result waits for the register to drain
`include "pid_motor_position_control_defines.svh"

module pid_motor_position_control (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// measured_angle[15:0], target_angle[31:16], dt_us[51:32], enable[52], zero fill
	input  logic [pmpc_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// kind[1:0]
	input  logic [pmpc_pkg::KIND_W-1:0]         s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// drive_mode[1:0], duty[9:2], holding[10], reached[11], angle_error[28:12], zero fill
	output logic [pmpc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [pmpc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pmpc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
	import pmpc_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	res_t  res;
	res_t  out_q;
	logic  out_valid_q;
	logic  out_free;
	logic  res_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain  <= RST_PROP_GAIN;
			cfg_q.deriv_gain <= RST_DERIV_GAIN;
			cfg_q.integ_gain <= RST_INTEG_GAIN;
			cfg_q.hold_band  <= RST_HOLD_BAND;
			cfg_q.slow_band  <= RST_SLOW_BAND;
			cfg_q.max_duty   <= RST_MAX_DUTY;
			cfg_q.slow_duty  <= RST_SLOW_DUTY;
			cfg_q.min_duty   <= RST_MIN_DUTY;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_wdata;
				REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_wdata;
				REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_wdata;
				REG_HOLD_BAND:  cfg_q.hold_band  <= cfg_wdata[HB_W-1:0];
				REG_SLOW_BAND:  cfg_q.slow_band  <= cfg_wdata[SB_W-1:0];
				REG_MAX_DUTY:   cfg_q.max_duty   <= cfg_wdata[DUTY_W-1:0];
				REG_SLOW_DUTY:  cfg_q.slow_duty  <= cfg_wdata[DUTY_W-1:0];
				REG_MIN_DUTY:   cfg_q.min_duty   <= cfg_wdata[DUTY_W-1:0];
				default: ;
			endcase
		end
	end

	assign item.kind           = s_axis_tuser;
	assign item.measured_angle = s_axis_tdata[15:0];
	assign item.target_angle   = s_axis_tdata[31:16];
	assign item.dt_us          = s_axis_tdata[51:32];
	assign item.enable         = s_axis_tdata[52];

	assign out_free = !out_valid_q || m_axis_tready;

	pmpc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.item      (item),
		.cfg       (cfg_q),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (res_valid)
			out_valid_q <= 1'b1;
		else if (m_axis_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (res_valid)
			out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_q.angle_error, out_q.reached, out_q.holding,
		out_q.duty, out_q.drive_mode};

	`PMPC_ASSERT_IMP(a_reach_brake, m_axis_tvalid && out_q.reached,
		out_q.holding && (out_q.drive_mode == MODE_BRAKE), "arrival flagged outside brake hold")

endmodule

[rtl/core/pmpc_div.sv]
// shared unsigned restoring divider, two quotient bits per cycle
// depends on pmpc_pkg and the assertion macro header
`include "pid_motor_position_control_defines.svh"

module pmpc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  pmpc_pkg::div_req_t  req,
	output pmpc_pkg::div_rsp_t  rsp
);
	import pmpc_pkg::*;

	localparam int STEPS = 2;
	localparam int ITER  = DIV_N_W / STEPS;
	localparam int CNT_W = $clog2(ITER);

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [DIV_N_W-1:0] quo_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W-1:0] dvs_q;
	logic [DIV_N_W-1:0] quo_d;
	logic [DIV_D_W-1:0] rem_d;

	always_comb begin
		logic [DIV_D_W:0] r;
		logic             ge;
		quo_d = quo_q;
		rem_d = rem_q;
		for (int i = 0; i < STEPS; i++) begin
			r     = {rem_d, quo_d[DIV_N_W-1]};
			ge    = (r >= {1'b0, dvs_q});
			rem_d = ge ? DIV_D_W'(r - {1'b0, dvs_q}) : r[DIV_D_W-1:0];
			quo_d = {quo_d[DIV_N_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ITER - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= quo_d;
			rem_q <= rem_d;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

	`PMPC_ASSERT_IMP(a_rem_below_dvs, busy_q, rem_q < dvs_q, "divider remainder not below divisor")

endmodule

[rtl/core/pmpc_seq.sv]
// tick sequencer: error, hold band, shared multiplier and pid sum with limits
// depends on pmpc_pkg, pmpc_div and the assertion macro header
`include "pid_motor_position_control_defines.svh"

module pmpc_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  pmpc_pkg::item_t item,
	input  pmpc_pkg::cfg_t  cfg,
	input  logic            out_free,
	output logic            res_valid,
	output pmpc_pkg::res_t  res
);
	import pmpc_pkg::*;

	localparam int MUL_A_W = 40;
	localparam int MUL_B_W = 20;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;
	localparam int SUM_W   = DIV_N_W + 2;
	localparam int P_W     = 32;
	localparam int I_W     = 32;
	localparam int ACC_W   = INTEG_W + 2;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_ERR   = 11'b00000000010,
		ST_M1    = 11'b00000000100,
		ST_M2    = 11'b00000001000,
		ST_M3    = 11'b00000010000,
		ST_M4    = 11'b00000100000,
		ST_M5    = 11'b00001000000,
		ST_DIV_D = 11'b00010000000,
		ST_DIV_I = 11'b00100000000,
		ST_SUM   = 11'b01000000000,
		ST_LIM   = 11'b10000000000
	} state_t;

	function automatic logic signed [ERR_W-1:0] wrap_err(
		input logic [ANG_W-1:0] tgt,
		input logic [ANG_W-1:0] meas
	);
		logic signed [ERR_W:0] d;
		d = $signed({2'b00, tgt}) - $signed({2'b00, meas});
		if (d > HALF_TURN)
			d = d - FULL_TURN;
		else if (d < -HALF_TURN)
			d = d + FULL_TURN;
		return d[ERR_W-1:0];
	endfunction

	function automatic logic signed [SUM_W-1:0] apply_sign(
		input logic               neg,
		input logic [DIV_N_W-1:0] mag
	);
		logic signed [SUM_W-1:0] ext;
		ext = $signed({2'b00, mag});
		return neg ? -ext : ext;
	endfunction

	state_t                     state_q;
	item_t                      item_q;
	logic [ANG_W-1:0]           target_q;
	logic signed [ERR_W-1:0]    prev_q;
	logic signed [INTEG_W-1:0]  integ_q;
	logic                       active_q;
	logic                       holding_q;
	logic                       reported_q;

	logic signed [ERR_W-1:0]    err_q;
	logic [ERR_W-1:0]           aerr_q;
	logic [DT_W-1:0]            dt_q;
	logic                       dneg_q;
	logic [P_W-1:0]             p_q;
	logic [DIV_N_W-1:0]         d_q;
	logic [I_W-1:0]             i_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [MUL_P_W-1:0]         mul_q;

	logic signed [ERR_W-1:0]    err_c;
	logic signed [ERR_W-1:0]    set_err_c;
	logic [ERR_W-1:0]           aerr_c;
	logic                       in_band_c;
	logic signed [ERR_W:0]      diff_c;
	logic [ERR_W:0]             adiff_c;
	logic signed [ACC_W-1:0]    term_c;
	logic signed [ACC_W-1:0]    acc_c;
	logic [INTEG_W-1:0]         aacc_c;
	logic [SUM_W-1:0]           msum_c;
	logic [SUM_W-17:0]          mag_c;
	logic [DUTY_W-1:0]          mx_c;
	logic [DUTY_W-1:0]          lim_c;
	logic [DUTY_W-1:0]          duty_c;
	logic                       mul_en;
	logic [MUL_A_W-1:0]         mul_a;
	logic [MUL_B_W-1:0]         mul_b;
	div_req_t                   div_req;
	div_rsp_t                   div_rsp;

	pmpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		err_c     = wrap_err(target_q, item_q.measured_angle);
		set_err_c = wrap_err(item_q.target_angle, item_q.measured_angle);
		aerr_c    = err_c[ERR_W-1] ? ERR_W'(-err_c) : ERR_W'(err_c);
		in_band_c = (aerr_c <= ERR_W'(cfg.hold_band)) ||
			((target_q == '0) && (aerr_c <= ZERO_TOL));

		diff_c  = $signed({err_q[ERR_W-1], err_q}) - $signed({prev_q[ERR_W-1], prev_q});
		adiff_c = diff_c[ERR_W] ? (ERR_W+1)'(-diff_c) : (ERR_W+1)'(diff_c);

		term_c = $signed({2'b00, mul_q[INTEG_W-1:0]});
		if (err_q[ERR_W-1])
			term_c = -term_c;
		acc_c = $signed({{2{integ_q[INTEG_W-1]}}, integ_q}) + term_c;
		if (acc_c > INTEG_LIM)
			acc_c = INTEG_LIM;
		else if (acc_c < -INTEG_LIM)
			acc_c = -INTEG_LIM;
		aacc_c = integ_q[INTEG_W-1] ? INTEG_W'(-integ_q) : INTEG_W'(integ_q);

		msum_c = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
		mag_c  = msum_c[SUM_W-1:16];
		mx_c   = (cfg.max_duty < DUTY_LO) ? DUTY_LO : cfg.max_duty;
		lim_c  = (aerr_q <= ERR_W'(cfg.slow_band)) ? cfg.slow_duty : mx_c;
		duty_c = (mag_c > (SUM_W-16)'(lim_c)) ? lim_c : mag_c[DUTY_W-1:0];
		if (duty_c != '0 && duty_c < cfg.min_duty)
			duty_c = cfg.min_duty;
	end

	// shared multiplier operand select
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_M1: begin
				mul_a = MUL_A_W'(aerr_q);
				mul_b = dt_q;
			end
			ST_M2: begin
				mul_a = MUL_A_W'(aerr_q);
				mul_b = MUL_B_W'(cfg.prop_gain);
			end
			ST_M3: begin
				mul_a = MUL_A_W'(adiff_c);
				mul_b = MUL_B_W'(cfg.deriv_gain);
			end
			ST_M4: begin
				mul_a = mul_q[MUL_A_W-1:0];
				mul_b = US_PER_S;
			end
			ST_M5: begin
				mul_a = MUL_A_W'(aacc_c);
				mul_b = MUL_B_W'(cfg.integ_gain);
			end
			default: mul_en = 1'b0;
		endcase
	end

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = mul_q[DIV_N_W-1:0];
		div_req.divisor  = dt_q;
		if (state_q == ST_M5)
			div_req.start = 1'b1;
		else if (state_q == ST_DIV_D && div_rsp.done) begin
			div_req.start   = 1'b1;
			div_req.divisor = US_PER_S;
		end
	end

	always_comb begin
		res_valid       = 1'b0;
		res.drive_mode  = MODE_COAST;
		res.duty        = '0;
		res.holding     = 1'b0;
		res.reached     = 1'b0;
		res.angle_error = err_c;
		if (state_q == ST_ERR && item_q.kind == KIND_TICK) begin
			if (!item_q.enable || !active_q) begin
				res_valid = out_free;
			end else if (in_band_c) begin
				res_valid      = out_free;
				res.drive_mode = MODE_BRAKE;
				res.holding    = 1'b1;
				res.reached    = !reported_q;
			end
		end else if (state_q == ST_LIM) begin
			res_valid       = out_free;
			res.drive_mode  = sum_q[SUM_W-1] ? MODE_REV : MODE_FWD;
			res.duty        = duty_c;
			res.angle_error = err_q;
		end
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			target_q   <= '0;
			prev_q     <= '0;
			integ_q    <= '0;
			active_q   <= 1'b0;
			holding_q  <= 1'b0;
			reported_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_ERR;
				end
				ST_ERR: begin
					unique case (item_q.kind)
						KIND_SET: begin
							target_q   <= item_q.target_angle;
							integ_q    <= '0;
							prev_q     <= set_err_c;
							active_q   <= 1'b1;
							holding_q  <= 1'b0;
							reported_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
						KIND_STOP: begin
							target_q   <= item_q.measured_angle;
							integ_q    <= '0;
							prev_q     <= '0;
							active_q   <= 1'b0;
							holding_q  <= 1'b0;
							reported_q <= 1'b0;
							state_q    <= ST_IDLE;
						end
						KIND_TICK: begin
							if (!item_q.enable) begin
								if (out_free) begin
									integ_q    <= '0;
									prev_q     <= '0;
									active_q   <= 1'b0;
									holding_q  <= 1'b0;
									reported_q <= 1'b0;
									state_q    <= ST_IDLE;
								end
							end else if (!active_q) begin
								if (out_free)
									state_q <= ST_IDLE;
							end else if (in_band_c) begin
								if (out_free) begin
									integ_q    <= '0;
									prev_q     <= err_c;
									holding_q  <= 1'b1;
									reported_q <= 1'b1;
									state_q    <= ST_IDLE;
								end
							end else begin
								// leaving the hold band restarts the loop
								if (holding_q) begin
									holding_q  <= 1'b0;
									reported_q <= 1'b0;
									integ_q    <= '0;
									prev_q     <= err_c;
								end
								state_q <= ST_M1;
							end
						end
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_M1: state_q <= ST_M2;
				ST_M2: begin
					integ_q <= acc_c[INTEG_W-1:0];
					state_q <= ST_M3;
				end
				ST_M3: state_q <= ST_M4;
				ST_M4: state_q <= ST_M5;
				ST_M5: state_q <= ST_DIV_D;
				ST_DIV_D: begin
					if (div_rsp.done)
						state_q <= ST_DIV_I;
				end
				ST_DIV_I: begin
					if (div_rsp.done)
						state_q <= ST_SUM;
				end
				ST_SUM: state_q <= ST_LIM;
				ST_LIM: begin
					if (out_free) begin
						prev_q  <= err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid)
			item_q <= item;
		if (state_q == ST_ERR) begin
			err_q  <= err_c;
			aerr_q <= aerr_c;
			dt_q   <= (item_q.dt_us == '0) ? DT_DEFAULT : item_q.dt_us;
		end
		if (mul_en)
			mul_q <= mul_a * mul_b;
		if (state_q == ST_M3) begin
			p_q    <= mul_q[P_W-1:0];
			dneg_q <= diff_c[ERR_W];
		end
		if (state_q == ST_DIV_D && div_rsp.done)
			d_q <= div_rsp.quot;
		if (state_q == ST_DIV_I && div_rsp.done)
			i_q <= div_rsp.quot[I_W-1:0];
		if (state_q == ST_SUM)
			sum_q <= apply_sign(err_q[ERR_W-1], DIV_N_W'(p_q)) +
				apply_sign(dneg_q, d_q) +
				apply_sign(integ_q[INTEG_W-1], DIV_N_W'(i_q));
	end

	`PMPC_ASSERT_NEXT(a_div_launch, div_req.start, div_rsp.busy, "divider did not start")
	`PMPC_ASSERT_IMP(a_integ_clamp, 1'b1,
		(integ_q <= INTEG_LIM) && (integ_q >= -INTEG_LIM), "integral outside its clamp")

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for pid_motor_position_control: random stream traffic,
// in-line prediction of every control tick, several register settings
// depends on pmpc_pkg and the rtl of the block
module tb;
	import pmpc_pkg::*;

	localparam int ANGLE_TOP = 46080;
	localparam int DT_TOP = 1048575;
	localparam int QUIET_LIMIT = 20000;
	localparam int CHOKE_CYCLES = 1500;
	localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

	bit clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic [KIND_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	pid_motor_position_control u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// loop state and register copy of the predictor
	cfg_t cfg;
	logic [ANG_W-1:0] target_q;
	longint prev_err;
	longint integ;
	bit loop_on, holding_on, reported;

	item_t pending[$];
	res_t due_outputs[$];
	item_t cur_item;
	res_t want;
	bit offering;
	int send_gap;
	int rx_stall;
	bit no_gaps;
	bit choke_req;
	int quiet_cycles;
	int fails;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(40, 250);
	endfunction

	function automatic longint angle_diff(input logic [ANG_W-1:0] t, input logic [ANG_W-1:0] m);
		longint d;
		longint half;
		longint full;
		half = HALF_TURN;
		full = FULL_TURN;
		d = longint'(t) - longint'(m);
		if (d > half) d -= full;
		if (d < -half) d += full;
		return d;
	endfunction

	function automatic void clear_loop();
		loop_on = 1'b0;
		holding_on = 1'b0;
		reported = 1'b0;
		integ = 0;
		prev_err = 0;
	endfunction

	function automatic void predict_control(input item_t c);
		longint err, aerr, dt, acc, sum, mag, lim, mx;
		longint kp, kd, ki, usec, ilim, hband, sband, ztol, mind;
		res_t r;
		kp = cfg.prop_gain;
		kd = cfg.deriv_gain;
		ki = cfg.integ_gain;
		hband = cfg.hold_band;
		sband = cfg.slow_band;
		mind = cfg.min_duty;
		usec = US_PER_S;
		ilim = INTEG_LIM;
		ztol = ZERO_TOL;
		if (c.kind == KIND_SET) begin
			target_q = c.target_angle;
			integ = 0;
			prev_err = angle_diff(c.target_angle, c.measured_angle);
			loop_on = 1'b1;
			holding_on = 1'b0;
			reported = 1'b0;
			return;
		end
		if (c.kind == KIND_STOP) begin
			target_q = c.measured_angle;
			clear_loop();
			return;
		end
		if (c.kind != KIND_TICK) return;

		err = angle_diff(target_q, c.measured_angle);
		aerr = (err < 0) ? -err : err;
		r.drive_mode = MODE_COAST;
		r.duty = '0;
		r.holding = 1'b0;
		r.reached = 1'b0;
		r.angle_error = err[ERR_W-1:0];

		if (!c.enable) begin
			clear_loop();
		end else if (loop_on) begin
			if (aerr <= hband || (target_q == 0 && aerr <= ztol)) begin
				r.drive_mode = MODE_BRAKE;
				r.holding = 1'b1;
				integ = 0;
				prev_err = err;
				holding_on = 1'b1;
				if (!reported) begin
					r.reached = 1'b1;
					reported = 1'b1;
				end
			end else begin
				if (holding_on) begin
					holding_on = 1'b0;
					reported = 1'b0;
					integ = 0;
					prev_err = err;
				end
				dt = c.dt_us;
				if (dt == 0) dt = DT_DEFAULT;
				acc = integ + err * dt;
				if (acc > ilim) acc = ilim;
				if (acc < -ilim) acc = -ilim;
				integ = acc;
				sum = kp * err + (kd * (err - prev_err) * usec) / dt + (ki * acc) / usec;
				mag = (sum < 0) ? -sum : sum;
				mag = mag >> 16;
				mx = cfg.max_duty;
				if (mx < DUTY_LO) mx = DUTY_LO;
				if (aerr <= sband) lim = cfg.slow_duty;
				else lim = mx;
				if (mag > lim) mag = lim;
				if (mag > 0 && mag < mind) mag = mind;
				r.duty = mag[DUTY_W-1:0];
				r.drive_mode = (sum < 0) ? MODE_REV : MODE_FWD;
				prev_err = err;
			end
		end
		due_outputs.push_back(r);
	endfunction

	// sender: one transaction offered at a time, random gaps between them
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
			offering = 1'b0;
			send_gap = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				predict_control(cur_item);
				offering = 1'b0;
			end
			if (!offering) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending.size() != 0) begin
					cur_item = pending.pop_front();
					offering = 1'b1;
					send_gap = pick_gap();
				end
			end
			s_axis_tvalid <= offering;
			s_axis_tdata <= {3'b000, cur_item.enable, cur_item.dt_us,
				cur_item.target_angle, cur_item.measured_angle};
			s_axis_tuser <= cur_item.kind;
		end
	end

	// receiver: checks each result transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (due_outputs.size() == 0) begin
					$error("unexpected result transaction, tdata %h", m_axis_tdata);
					fails++;
				end else begin
					want = due_outputs.pop_front();
					if (m_axis_tdata[1:0] !== want.drive_mode) begin
						$error("drive_mode expected %0d got %0d", want.drive_mode,
							m_axis_tdata[1:0]);
						fails++;
					end
					if (m_axis_tdata[9:2] !== want.duty) begin
						$error("duty expected %0d got %0d", want.duty, m_axis_tdata[9:2]);
						fails++;
					end
					if (m_axis_tdata[10] !== want.holding) begin
						$error("holding expected %0d got %0d", want.holding, m_axis_tdata[10]);
						fails++;
					end
					if (m_axis_tdata[11] !== want.reached) begin
						$error("reached expected %0d got %0d", want.reached, m_axis_tdata[11]);
						fails++;
					end
					if (m_axis_tdata[28:12] !== want.angle_error) begin
						$error("angle_error expected %0d got %0d", want.angle_error,
							$signed(m_axis_tdata[28:12]));
						fails++;
					end
				end
			end
			if (choke_req) begin
				rx_stall = CHOKE_CYCLES;
				choke_req = 1'b0;
			end else if (rx_stall == 0 && $urandom_range(0, 99) < 15) begin
				rx_stall = pick_gap();
			end
			m_axis_tready <= (rx_stall == 0);
			if (rx_stall > 0) rx_stall--;
		end
	end

	// ends the run when no transaction moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("simulation failed");
					$finish;
				end
			end
		end
	end

	task automatic add_item(input int k, input int m, input int t, input int d, input int e);
		item_t it;
		it.kind = KIND_W'(k);
		it.measured_angle = ANG_W'(m);
		it.target_angle = ANG_W'(t);
		it.dt_us = DT_W'(d);
		it.enable = 1'(e);
		pending.push_back(it);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_PROP_GAIN: cfg.prop_gain = val;
			REG_DERIV_GAIN: cfg.deriv_gain = val;
			REG_INTEG_GAIN: cfg.integ_gain = val;
			REG_HOLD_BAND: cfg.hold_band = val[HB_W-1:0];
			REG_SLOW_BAND: cfg.slow_band = val[SB_W-1:0];
			REG_MAX_DUTY: cfg.max_duty = val[DUTY_W-1:0];
			REG_SLOW_DUTY: cfg.slow_duty = val[DUTY_W-1:0];
			REG_MIN_DUTY: cfg.min_duty = val[DUTY_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_settings(input int kp, input int kd, input int ki, input int hb,
			input int sb, input int mx, input int sd, input int md);
		write_reg(REG_PROP_GAIN, CFG_DATA_W'(kp));
		write_reg(REG_DERIV_GAIN, CFG_DATA_W'(kd));
		write_reg(REG_INTEG_GAIN, CFG_DATA_W'(ki));
		write_reg(REG_HOLD_BAND, CFG_DATA_W'(hb));
		write_reg(REG_SLOW_BAND, CFG_DATA_W'(sb));
		write_reg(REG_MAX_DUTY, CFG_DATA_W'(mx));
		write_reg(REG_SLOW_DUTY, CFG_DATA_W'(sd));
		write_reg(REG_MIN_DUTY, CFG_DATA_W'(md));
	endtask

	task automatic wait_idle();
		while (pending.size() != 0 || offering || due_outputs.size() != 0)
			@(posedge clk);
		// set-target and stop transactions give no result and may still be in work
		repeat (16) @(posedge clk);
	endtask

	function automatic int pick_angle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 10) return 0;
		if (r < 20) return ANGLE_TOP;
		return $urandom_range(0, ANGLE_TOP);
	endfunction

	function automatic int pick_dt();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5) return 0;
		if (r < 10) return 1;
		if (r < 15) return DT_TOP;
		if (r < 25) return $urandom_range(0, DT_TOP);
		return $urandom_range(2000, 20000);
	endfunction

	// mostly set-target followed by ticks that close in on the target
	task automatic random_items(input int n);
		int made, len, off, scale, jit, push, m, t;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 99) < 80) begin
				t = pick_angle();
				m = pick_angle();
				add_item(KIND_SET, m, t, pick_dt(), $urandom_range(0, 1));
				made++;
				off = t - m;
				len = $urandom_range(3, 25);
				for (int i = 0; i < len; i++) begin
					scale = $urandom_range(30, 95);
					jit = $urandom_range(0, 300);
					off = off * scale / 100 + jit - 150;
					if ($urandom_range(0, 7) == 0) begin
						push = $urandom_range(500, 6000);
						off = $urandom_range(0, 1) ? off + push : off - push;
					end
					m = t - off;
					if (m < 0) m = 0;
					if (m > ANGLE_TOP) m = ANGLE_TOP;
					add_item(KIND_TICK, m, $urandom_range(0, ANGLE_TOP), pick_dt(),
						$urandom_range(0, 99) < 96);
					made++;
				end
				if ($urandom_range(0, 3) == 0) begin
					add_item(KIND_STOP, pick_angle(), pick_angle(), pick_dt(), 1);
					made++;
				end
			end else begin
				add_item($urandom_range(0, 3), pick_angle(), pick_angle(), pick_dt(),
					$urandom_range(0, 1));
				made++;
			end
		end
	endtask

	initial begin
		cfg.prop_gain = RST_PROP_GAIN;
		cfg.deriv_gain = RST_DERIV_GAIN;
		cfg.integ_gain = RST_INTEG_GAIN;
		cfg.hold_band = RST_HOLD_BAND;
		cfg.slow_band = RST_SLOW_BAND;
		cfg.max_duty = RST_MAX_DUTY;
		cfg.slow_duty = RST_SLOW_DUTY;
		cfg.min_duty = RST_MIN_DUTY;
		target_q = '0;
		clear_loop();
		fails = 0;
		quiet_cycles = 0;
		no_gaps = 1'b0;
		choke_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part under the reset register values
		add_item(KIND_TICK, 1000, 0, 10000, 1);
		add_item(KIND_SPARE, 5000, 9999, 10000, 1);
		add_item(KIND_TICK, 0, 0, 10000, 0);
		add_item(KIND_SET, ANGLE_TOP, 0, 10000, 1);
		add_item(KIND_TICK, ANGLE_TOP, ANGLE_TOP, DT_TOP, 1);
		add_item(KIND_TICK, 2000, 0, 10000, 1);
		add_item(KIND_TICK, 1500, 0, 10000, 1);
		add_item(KIND_TICK, 3000, 0, 10000, 1);
		add_item(KIND_TICK, 100, 0, 10000, 1);
		add_item(KIND_SET, 0, ANGLE_TOP, 10000, 1);
		add_item(KIND_TICK, 0, 0, 0, 1);
		add_item(KIND_TICK, ANGLE_TOP - 200, 0, 10000, 1);
		add_item(KIND_TICK, ANGLE_TOP - 100, 0, 10000, 0);
		add_item(KIND_TICK, ANGLE_TOP - 100, 0, 10000, 1);
		add_item(KIND_SET, 19000, 20000, 10000, 1);
		add_item(KIND_TICK, 19500, 0, 1, 1);
		add_item(KIND_TICK, 21000, 0, 10000, 1);
		add_item(KIND_TICK, 30000, 0, 1, 1);
		add_item(KIND_TICK, 5000, 0, 0, 1);
		add_item(KIND_STOP, 12345, 0, 10000, 1);
		add_item(KIND_TICK, 12000, 0, 10000, 1);
		add_item(KIND_SET, 12000, 0, 10000, 1);
		add_item(KIND_TICK, 12000, ANGLE_TOP, 5000, 1);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: load_settings(0, 0, 0, 0, 0, 0, 0, 0);
				1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 2560, 7680, 255, 255, 255);
				3: load_settings($urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
				4: load_settings(448, 40, 32, 256, 1280, 100, 60, 200);
				default: load_settings($urandom_range(100, 3000), $urandom_range(0, 300),
					$urandom_range(0, 400), $urandom_range(0, 2560),
					$urandom_range(0, 7680), $urandom_range(0, 255),
					$urandom_range(0, 255), $urandom_range(0, 255));
			endcase
			no_gaps = (ph == 5);
			if (ph == 2) choke_req = 1'b1;
			random_items(250);
			wait_idle();
		end
		no_gaps = 1'b0;

		repeat (100) @(posedge clk);
		if (due_outputs.size() != 0) begin
			$error("%0d predicted results never arrived", due_outputs.size());
			fails++;
		end
		if (fails == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
